FILE: sv/rrcd_pkg.sv
// Shared constants and types for the random replacement cache directory.
`timescale 1ns / 1ps

package rrcd_pkg;

  localparam int NUM_ENTRIES = 256;
  localparam int BLOCK_BYTES = 1024;
  localparam int RAM_BYTES   = 16777216;

  localparam int IDX_W  = $clog2(NUM_ENTRIES);
  localparam int OFF_W  = $clog2(BLOCK_BYTES);
  localparam int ADDR_W = $clog2(RAM_BYTES);
  localparam int TAG_W  = ADDR_W - OFF_W;

  // Tag store is organized as rows of lanes so the scan checks a row per cycle.
  localparam int LANES  = 8;
  localparam int LANE_W = $clog2(LANES);
  localparam int ROWS   = NUM_ENTRIES / LANES;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [31:0] SEED_DEFAULT = 32'hABC8_9105;
  localparam int          RNG_SHIFT    = 7;

  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_HALF = 2'd1,
    SIZE_WORD = 2'd2,
    SIZE_RSVD = 2'd3
  } size_e;

  localparam logic OP_STORE = 1'b1;

  typedef struct packed {
    logic             is_store;
    logic [TAG_W-1:0] blk;
    logic [OFF_W-1:0] off;
    logic [OFF_W-1:0] last;   // last byte touched, saturated at block end
  } job_t;

  typedef struct packed {
    logic [IDX_W-1:0] entry_index;
    logic             hit;
    logic [OFF_W-1:0] in_block_offset;
    logic             writeback_needed;
    logic [TAG_W-1:0] victim_block;
    logic [OFF_W-1:0] writeback_low;
    logic [OFF_W-1:0] writeback_high;
    logic [TAG_W-1:0] fill_block;
  } result_t;

  typedef struct packed {
    logic [OFF_W-1:0] lo;
    logic [OFF_W-1:0] hi;
  } range_t;

  function automatic logic [31:0] xorshift32(input logic [31:0] x);
    logic [31:0] a;
    logic [31:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

FILE: sv/rrcd_front.sv
// Front end: accepts accesses and splits them into block, offset and store range.
`timescale 1ns / 1ps

module rrcd_front import rrcd_pkg::*; (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              opcode_i,
  input  logic [ADDR_W-1:0] byte_offset_i,
  input  logic [1:0]        access_size_i,
  output logic              push_o,
  output job_t              push_job_o,
  input  logic              full_i
);

  logic [OFF_W-1:0] off;
  logic [OFF_W:0]   last_ext;
  logic [OFF_W:0]   span;

  assign off = byte_offset_i[OFF_W-1:0];

  always_comb begin
    case (size_e'(access_size_i))
      SIZE_HALF: span = (OFF_W+1)'(1);
      SIZE_WORD: span = (OFF_W+1)'(3);
      default:   span = '0;
    endcase
    last_ext = {1'b0, off} + span;
    push_job_o.is_store = (opcode_i == OP_STORE);
    push_job_o.blk      = byte_offset_i[ADDR_W-1:OFF_W];
    push_job_o.off      = off;
    // Saturate at the last byte of the block.
    push_job_o.last     = last_ext[OFF_W] ? '1 : last_ext[OFF_W-1:0];
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

FILE: sv/rrcd_queue.sv
// Short FIFO of classified accesses between front end and back end.
`timescale 1ns / 1ps

module rrcd_queue import rrcd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  input  logic pop_i,
  output logic avail_o,
  output job_t pop_job_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  job_t                   slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]         count_q;

  assign full_o    = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign avail_o   = (count_q != '0);
  assign pop_job_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (PTR_W+1)'(push_i) - (PTR_W+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

FILE: sv/rrcd_back.sv
// Back end: hint check, row scan, victim pick, dirty range update, result register.
`timescale 1ns / 1ps

module rrcd_back import rrcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        avail_i,
  input  job_t        job_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output result_t     res_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RH,
    S_OH,
    S_SCAN,
    S_UPD
  } state_e;

  state_e            state_q;
  job_t              job_q;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              hit_q;
  logic [ROW_W-1:0]  scan_row_q;
  logic [IDX_W-1:0]  rh_q, oh_q;
  logic [31:0]       rng_q;
  logic [31:0]       rng_next;
  logic [NUM_ENTRIES-1:0] valid_q, dirty_q;
  logic              out_valid_q;
  result_t           res_q;

  // Memories: tags by row and lane, dirty ranges by entry.
  logic [TAG_W-1:0]  tag_mem   [ROWS][LANES];
  range_t            range_mem [NUM_ENTRIES];
  logic [TAG_W-1:0]  tag_row_q [LANES];
  range_t            range_q;
  logic [ROW_W-1:0]  rd_row;

  logic              rh_hit, oh_hit, row_hit, last_row, victim_dirty;
  logic [LANE_W-1:0] hit_lane;
  logic [IDX_W-1:0]  victim;
  logic              can_out, upd_go;
  range_t            new_range;

  function automatic logic [ROW_W-1:0] row_of(input logic [IDX_W-1:0] i);
    return ROW_W'(i >> LANE_W);
  endfunction

  assign rng_next = xorshift32(rng_q);
  assign victim   = rng_next[RNG_SHIFT +: IDX_W];
  assign rh_hit   = valid_q[rh_q] && (tag_row_q[rh_q[LANE_W-1:0]] == job_q.blk);
  assign oh_hit   = valid_q[oh_q] && (tag_row_q[oh_q[LANE_W-1:0]] == job_q.blk);
  assign last_row = (scan_row_q == ROW_W'(ROWS-1));

  // Lowest matching lane of the row under scan.
  always_comb begin
    row_hit  = 1'b0;
    hit_lane = '0;
    for (int l = LANES-1; l >= 0; l--) begin
      if (valid_q[IDX_W'(scan_row_q) * IDX_W'(LANES) + IDX_W'(l)] &&
          tag_row_q[l] == job_q.blk) begin
        row_hit  = 1'b1;
        hit_lane = LANE_W'(l);
      end
    end
  end

  always_comb begin
    idx_d  = idx_q;
    rd_row = row_of(idx_q);
    case (state_q)
      S_IDLE: rd_row = row_of(rh_q);
      S_RH: begin
        rd_row = row_of(oh_q);
        if (rh_hit) idx_d = rh_q;
      end
      S_OH: begin
        rd_row = '0;
        if (oh_hit) idx_d = oh_q;
      end
      S_SCAN: begin
        if (row_hit) begin
          idx_d = IDX_W'(scan_row_q) * IDX_W'(LANES) + IDX_W'(hit_lane);
        end else if (last_row) begin
          idx_d  = victim;
          rd_row = row_of(victim);
        end else begin
          rd_row = scan_row_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign can_out      = !out_valid_q || !out_stall_i;
  assign upd_go       = (state_q == S_UPD) && can_out;
  assign pop_o        = (state_q == S_IDLE) && avail_i;
  assign victim_dirty = valid_q[idx_q] && dirty_q[idx_q];

  // Range written at a store's update: a hit on a dirty entry widens, anything else restarts.
  always_comb begin
    new_range.lo = job_q.off;
    new_range.hi = job_q.last;
    if (hit_q && dirty_q[idx_q]) begin
      if (range_q.lo < job_q.off)  new_range.lo = range_q.lo;
      if (range_q.hi > job_q.last) new_range.hi = range_q.hi;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_row_q <= tag_mem[rd_row];
    range_q   <= range_mem[idx_d];
    if (upd_go && !hit_q) begin
      tag_mem[row_of(idx_q)][idx_q[LANE_W-1:0]] <= job_q.blk;
    end
    if (upd_go && job_q.is_store) begin
      range_mem[idx_q] <= new_range;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      job_q       <= '0;
      idx_q       <= '0;
      hit_q       <= 1'b0;
      scan_row_q  <= '0;
      rh_q        <= '0;
      oh_q        <= '0;
      rng_q       <= SEED_DEFAULT;
      valid_q     <= '0;
      dirty_q     <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        rng_q <= cfg_wdata_i;
      end
      if (out_valid_q && !out_stall_i && !upd_go) begin
        out_valid_q <= 1'b0;
      end
      idx_q <= idx_d;
      case (state_q)
        S_IDLE: begin
          if (avail_i) begin
            job_q   <= job_i;
            state_q <= S_RH;
          end
        end
        S_RH: begin
          if (rh_hit) begin
            hit_q   <= 1'b1;
            state_q <= S_UPD;
          end else begin
            state_q <= S_OH;
          end
        end
        S_OH: begin
          if (oh_hit) begin
            hit_q   <= 1'b1;
            state_q <= S_UPD;
          end else begin
            scan_row_q <= '0;
            state_q    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (row_hit || last_row) begin
            hit_q   <= row_hit;
            oh_q    <= rh_q;
            rh_q    <= idx_d;
            state_q <= S_UPD;
            if (!row_hit) rng_q <= rng_next;
          end else begin
            scan_row_q <= scan_row_q + 1'b1;
          end
        end
        S_UPD: begin
          if (can_out) begin
            res_q.entry_index     <= idx_q;
            res_q.hit             <= hit_q;
            res_q.in_block_offset <= job_q.off;
            res_q.writeback_needed <= !hit_q && victim_dirty;
            res_q.victim_block    <= (!hit_q && victim_dirty) ?
                                     tag_row_q[idx_q[LANE_W-1:0]] : '0;
            res_q.writeback_low   <= (!hit_q && victim_dirty) ? range_q.lo : '0;
            res_q.writeback_high  <= (!hit_q && victim_dirty) ? range_q.hi : '0;
            res_q.fill_block      <= hit_q ? '0 : job_q.blk;
            out_valid_q           <= 1'b1;
            valid_q[idx_q]        <= 1'b1;
            dirty_q[idx_q]        <= job_q.is_store || (hit_q && dirty_q[idx_q]);
            hit_q                 <= 1'b0;
            state_q               <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

FILE: sv/random_replace_cache_directory.sv
// Top level of the random replacement cache directory.
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one access: opcode_i
//   (load or store), byte_offset_i and access_size_i. A transfer happens on
//   a rising edge with valid high and stall low.
//   Output channel (out_valid_o / out_stall_i) carries one result per access:
//   the entry now holding the block, hit, the in-block offset, the dirty
//   victim to write back and the block to fill on a miss.
//   cfg_we_i / cfg_wdata_i load the xorshift32 seed; write only while idle.
// Timing:
//   A two-deep queue decouples intake from the lookup engine, so accesses
//   are taken while a result waits. One access at a time is resolved: the
//   recent hint is checked first, then the older hint; otherwise the tag
//   store is scanned one row of 8 tags per cycle (32 rows) until a row hits
//   or the last row is passed, and a miss takes a victim from the xorshift32
//   generator.
// Reset:
//   Valid and dirty bits, hints and the queue clear; the generator reloads
//   the default seed. Tags and ranges are not cleared.
// Backpressure:
//   A stalled result holds; the engine waits at its update step and the
//   queue then fills and raises in_stall_o.
`timescale 1ns / 1ps

module random_replace_cache_directory import rrcd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              opcode_i,
  input  logic [ADDR_W-1:0] byte_offset_i,
  input  logic [1:0]        access_size_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [IDX_W-1:0]  entry_index_o,
  output logic              hit_o,
  output logic [OFF_W-1:0]  in_block_offset_o,
  output logic              writeback_needed_o,
  output logic [TAG_W-1:0]  victim_block_o,
  output logic [OFF_W-1:0]  writeback_low_o,
  output logic [OFF_W-1:0]  writeback_high_o,
  output logic [TAG_W-1:0]  fill_block_o
);

  logic    push, full, pop, avail;
  job_t    push_job, pop_job;
  result_t res;

  // Classify the access and push it into the queue.
  rrcd_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .byte_offset_i (byte_offset_i),
    .access_size_i (access_size_i),
    .push_o        (push),
    .push_job_o    (push_job),
    .full_i        (full)
  );

  rrcd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .avail_o    (avail),
    .pop_job_o  (pop_job)
  );

  // Resolve the lookup, update the directory and register the result.
  rrcd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .avail_i     (avail),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign entry_index_o      = res.entry_index;
  assign hit_o              = res.hit;
  assign in_block_offset_o  = res.in_block_offset;
  assign writeback_needed_o = res.writeback_needed;
  assign victim_block_o     = res.victim_block;
  assign writeback_low_o    = res.writeback_low;
  assign writeback_high_o   = res.writeback_high;
  assign fill_block_o       = res.fill_block;

endmodule

FILE: sv/rrcd_checker.sv
// Port-level checks for the random replacement cache directory, bound to the top.
`timescale 1ns / 1ps

module rrcd_checker import rrcd_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic             hit_o,
  input logic             writeback_needed_o,
  input logic [TAG_W-1:0] victim_block_o,
  input logic [OFF_W-1:0] writeback_low_o,
  input logic [OFF_W-1:0] writeback_high_o,
  input logic [TAG_W-1:0] fill_block_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(fill_block_o) && $stable(hit_o))
    else $error("result changed while stalled");

  a_hit_no_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> !writeback_needed_o && fill_block_o == '0)
    else $error("hit reported write-back or fill");

  a_clean_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !writeback_needed_o |->
      victim_block_o == '0 && writeback_low_o == '0 && writeback_high_o == '0)
    else $error("victim fields set without write-back");

  a_range_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && writeback_needed_o |-> writeback_low_o <= writeback_high_o)
    else $error("write-back range inverted");

endmodule

bind random_replace_cache_directory rrcd_checker u_rrcd_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .hit_o              (hit_o),
  .writeback_needed_o (writeback_needed_o),
  .victim_block_o     (victim_block_o),
  .writeback_low_o    (writeback_low_o),
  .writeback_high_o   (writeback_high_o),
  .fill_block_o       (fill_block_o)
);
